// ===== rtl/lpr_pkg.sv =====
package lpr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IFACE_COUNT = 16;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int IFACE_W = 4;
  localparam int TTL_W   = 8;

  localparam logic [LEN_W-1:0]  LEN_FULL  = LEN_W'(ADDR_W);
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

  localparam int IN_BITS    = ADDR_W + LEN_W + 1 + ADDR_W + IFACE_W + ADDR_W + TTL_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 3 + IFACE_W + ADDR_W + TTL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_FWD = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED       = 3'd0,
    ST_FORWARDED   = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_TTL_EXPIRED = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  // one routing table row
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic [IFACE_W-1:0] iface;
    logic               gw_valid;
    logic [ADDR_W-1:0]  gateway;
  } entry_t;

  // compare unit verdict
  typedef struct packed {
    logic hit;     // key address falls under the entry's prefix
    logic longer;  // entry prefix strictly longer than key length
  } match_t;

endpackage

// ===== rtl/lpr_ram.sv =====
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lpr_match.sv =====
module lpr_match (
  input  lpr_pkg::entry_t               entry,
  input  logic [lpr_pkg::ADDR_W-1:0]    key_addr,
  input  logic [lpr_pkg::LEN_W-1:0]     key_len,
  output lpr_pkg::match_t               res
);
  import lpr_pkg::*;

  logic [ADDR_W-1:0] mask;

  // length 0 gives an empty mask, length 32 shifts everything out: full mask
  assign mask       = ~(ADDR_ONES >> entry.len);
  assign res.hit    = ((key_addr ^ entry.prefix) & mask) == '0;
  assign res.longer = entry.len > key_len;

endmodule

// ===== rtl/ipv4_longest_prefix_router.sv =====
// Channel | Dir | Signals                  | Contents
// --------+-----+--------------------------+------------------------------------------
// s_*     | in  | s_tvalid s_tready s_tuser | tuser = action; tdata = route/datagram
// m_*     | out | m_tvalid m_tready m_tdata | status, interface, hop address, ttl
//
// One item at a time. A forward item goes at most through accept, one table
// read per entry through the single RAM read port and one compare unit, one
// check of the last read data, one no-match decision and result hand-off. An
// add goes through accept, the first read, a read-and-move of each entry that
// is not longer one row down, the insert write and result hand-off. A
// full-table add goes from accept straight to result hand-off. Reset clears
// state, entry count and output valid; the table RAM is never cleared since
// rows at or above the count are never read. A stalled result waits in the
// output register while the block returns to idle and accepts the next item.
module ipv4_longest_prefix_router (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tuser,  // [0] action
  // [31:0] net_prefix, [37:32] mask_len, [38] has_next_hop,
  // [70:39] next_hop_addr, [74:71] interface_index, [106:75] dst_addr,
  // [114:107] ttl_in, [119:115] zero
  input  logic [lpr_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] status, [6:3] out_interface, [38:7] hop_addr, [46:39] ttl_out,
  // [47] zero
  output logic [lpr_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import lpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] issue, issue_next;   // next row to read in scan, one above it in shift
  logic             pend, pend_next;     // RAM read data valid this cycle
  logic [IDX_W-1:0] pidx, pidx_next;     // row of the pending read in shift

  // latched item
  entry_t            new_entry;
  logic [ADDR_W-1:0] dst;
  logic [TTL_W-1:0]  ttl;

  // result staged for the output register
  status_t            res_status, res_status_next;
  logic [IFACE_W-1:0] res_iface, res_iface_next;
  logic [ADDR_W-1:0]  res_hop, res_hop_next;
  logic [TTL_W-1:0]   res_ttl, res_ttl_next;

  // RAM port
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  match_t mres;

  logic             accept;
  logic             out_load;
  logic [LEN_W-1:0] in_len;

  lpr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpr_match u_match (
    .entry    (rdata),
    .key_addr (dst),
    .key_len  (new_entry.len),
    .res      (mres)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  assign in_len = s_tdata[37:32];

  // latch the transaction fields; lengths above 32 saturate
  always_ff @(posedge clk) begin
    if (accept) begin
      new_entry.prefix   <= s_tdata[31:0];
      new_entry.len      <= (in_len > LEN_FULL) ? LEN_FULL : in_len;
      new_entry.gw_valid <= s_tdata[38];
      new_entry.gateway  <= s_tdata[70:39];
      new_entry.iface    <= s_tdata[74:71];
      dst                <= s_tdata[106:75];
      ttl                <= s_tdata[114:107];
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    issue_next      = issue;
    pend_next       = 1'b0;
    pidx_next       = pidx;
    res_status_next = res_status;
    res_iface_next  = res_iface;
    res_hop_next    = res_hop;
    res_ttl_next    = res_ttl;
    we              = 1'b0;
    waddr           = '0;
    wdata           = new_entry;
    raddr           = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_iface_next = '0;
          res_hop_next   = '0;
          res_ttl_next   = '0;
          if (s_tuser == ACT_FWD) begin
            issue_next = '0;
            state_next = S_SCAN;
          end else if (count == CNT_W'(TABLE_DEPTH)) begin
            res_status_next = ST_FULL;
            state_next      = S_FINISH;
          end else begin
            issue_next = count;
            state_next = S_SHIFT;
          end
        end
      end

      // walk rows from the top; first hit is the longest prefix
      S_SCAN: begin
        if (pend && mres.hit) begin
          state_next = S_FINISH;
          if (ttl <= TTL_W'(1)) begin
            res_status_next = ST_TTL_EXPIRED;
          end else begin
            res_status_next = ST_FORWARDED;
            res_iface_next  = rdata.iface;
            res_hop_next    = rdata.gw_valid ? rdata.gateway : dst;
            res_ttl_next    = ttl - TTL_W'(1);
          end
        end else if (issue < count) begin
          raddr      = issue[IDX_W-1:0];
          issue_next = issue + CNT_W'(1);
          pend_next  = 1'b1;
        end else if (!pend) begin
          res_status_next = ST_NO_ROUTE;
          state_next      = S_FINISH;
        end
      end

      // walk rows from the bottom, moving each one down until a longer
      // prefix is met; the new route goes just below it
      S_SHIFT: begin
        if (pend && mres.longer) begin
          we              = 1'b1;
          waddr           = IDX_W'(pidx + 1'b1);
          count_next      = count + CNT_W'(1);
          res_status_next = ST_ADDED;
          state_next      = S_FINISH;
        end else if (!pend && issue == '0) begin
          we              = 1'b1;
          waddr           = '0;
          count_next      = count + CNT_W'(1);
          res_status_next = ST_ADDED;
          state_next      = S_FINISH;
        end else begin
          if (pend) begin
            we    = 1'b1;
            waddr = IDX_W'(pidx + 1'b1);
            wdata = rdata;
          end
          if (issue != '0) begin
            raddr      = IDX_W'(issue - CNT_W'(1));
            pidx_next  = IDX_W'(issue - CNT_W'(1));
            issue_next = issue - CNT_W'(1);
            pend_next  = 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    issue      <= issue_next;
    pidx       <= pidx_next;
    res_status <= res_status_next;
    res_iface  <= res_iface_next;
    res_hop    <= res_hop_next;
    res_ttl    <= res_ttl_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({res_ttl, res_hop, res_iface, res_status});
    end
  end

endmodule

// ===== dv/lpr_route_checker.sv =====
module lpr_route_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic                           s_tuser,
  input  logic [lpr_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [lpr_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             mismatches,
  output int                             outstanding
);
  import lpr_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  hop;
    logic [TTL_W-1:0]   ttl;
  } route_result_t;

  // shadow routing table, longest prefix first
  entry_t        routes [TABLE_DEPTH];
  int            route_count;
  route_result_t pending_results [$];
  int            bad_count;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    if (len >= LEN_FULL)
      return ADDR_ONES;
    return ~(ADDR_ONES >> len);
  endfunction

  // applies one transaction to the shadow table and returns its answer
  function automatic route_result_t route_decision(input logic act,
                                                   input logic [IN_DATA_W-1:0] d);
    route_result_t     res;
    entry_t            fresh;
    int                pos;
    logic [ADDR_W-1:0] dst;
    logic [TTL_W-1:0]  ttl;
    logic [ADDR_W-1:0] m;
    bit                found;
    res = '0;
    if (act == ACT_ADD) begin
      fresh.prefix   = d[31:0];
      fresh.len      = (d[37:32] > LEN_FULL) ? LEN_FULL : d[37:32];
      fresh.gw_valid = d[38];
      fresh.gateway  = d[70:39];
      fresh.iface    = d[74:71];
      if (route_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < route_count && fresh.len < routes[pos].len)
          pos++;
        for (int k = route_count; k > pos; k--)
          routes[k] = routes[k-1];
        routes[pos] = fresh;
        route_count++;
        res.status = ST_ADDED;
      end
    end else begin
      dst   = d[106:75];
      ttl   = d[114:107];
      found = 0;
      pos   = 0;
      for (int k = 0; k < route_count && !found; k++) begin
        m = prefix_mask(routes[k].len);
        if ((dst & m) == (routes[k].prefix & m)) begin
          found = 1;
          pos   = k;
        end
      end
      if (!found) begin
        res.status = ST_NO_ROUTE;
      end else if (ttl <= 1) begin
        res.status = ST_TTL_EXPIRED;
      end else begin
        res.status = ST_FORWARDED;
        res.iface  = routes[pos].iface;
        res.hop    = routes[pos].gw_valid ? routes[pos].gateway : dst;
        res.ttl    = ttl - 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    route_result_t want, got;
    if (rst) begin
      route_count = 0;
      pending_results.delete();
      bad_count = 0;
    end else begin
      // result side first: a result can never belong to an item taken this edge
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[2:0]);
        got.iface  = m_tdata[6:3];
        got.hop    = m_tdata[38:7];
        got.ttl    = m_tdata[46:39];
        if (pending_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected result: status %0d iface %0d hop %h ttl %0d",
                     $time, got.status, got.iface, got.hop, got.ttl);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"%0t: mismatch (expected/actual): status %0d/%0d iface %0d/%0d",
                        " hop %h/%h ttl %0d/%0d"}, $time, want.status, got.status,
                       want.iface, got.iface, want.hop, got.hop, want.ttl, got.ttl);
          end
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(route_decision(s_tuser, s_tdata));
    end
    mismatches  <= bad_count;
    outstanding <= pending_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import lpr_pkg::*;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic                  s_tuser  = 1'b0;
  // [31:0] net_prefix, [37:32] mask_len, [38] has_next_hop,
  // [70:39] next_hop_addr, [74:71] interface_index, [106:75] dst_addr,
  // [114:107] ttl_in, [119:115] zero
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [2:0] status, [6:3] out_interface, [38:7] hop_addr, [46:39] ttl_out, [47] zero
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int outstanding;

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver stall, requested by the stimulus, timed by its own process
  logic stall_request = 1'b0;
  logic hold_off      = 1'b0;

  // what the stimulus knows it put in the table, used to aim destinations
  logic [ADDR_W-1:0] known_pfx [TABLE_DEPTH];
  int                known_len [TABLE_DEPTH];
  int                added_cnt = 0;

  ipv4_longest_prefix_router dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lpr_route_checker route_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop; the slowest legal run is far shorter
  initial begin
    #4000000;
    $display("ipv4_longest_prefix_router test failed");
    $finish;
  end

  // receiver: random back-pressure, or held low during the stall window
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // with the sender busy, the receiver stall fills the output register and
  // backs up into s_tready
  initial begin
    wait (stall_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [ADDR_W-1:0] pfx, input logic [LEN_W-1:0] len, input logic gw,
    input logic [ADDR_W-1:0] nh, input logic [IFACE_W-1:0] ifc,
    input logic [ADDR_W-1:0] dst, input logic [TTL_W-1:0] ttl);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[114:0] = {ttl, dst, ifc, nh, gw, len, pfx};
    return d;
  endfunction

  // one transaction on the input channel, with a random lead-in gap;
  // s_tvalid stays high when the next call follows with no gap
  task automatic send(input logic act, input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_add(input logic [ADDR_W-1:0] pfx, input logic [LEN_W-1:0] len,
                          input logic gw, input logic [ADDR_W-1:0] nh,
                          input logic [IFACE_W-1:0] ifc,
                          input logic [ADDR_W-1:0] dst, input logic [TTL_W-1:0] ttl);
    if (added_cnt < TABLE_DEPTH) begin
      known_pfx[added_cnt] = pfx;
      known_len[added_cnt] = (len > LEN_FULL) ? ADDR_W : len;
      added_cnt++;
    end
    send(ACT_ADD, pack_item(pfx, len, gw, nh, ifc, dst, ttl));
  endtask

  task automatic send_fwd(input logic [ADDR_W-1:0] dst, input logic [TTL_W-1:0] ttl);
    send(ACT_FWD, pack_item('0, '0, 1'b0, '0, '0, dst, ttl));
  endtask

  // Random mix. Adds are rare since only TABLE_DEPTH of them ever land; the
  // last free row takes the default route (/0) so that no-route answers stay
  // reachable for most of the run. Once full, some adds hit the full table.
  // Most forwards aim under a known prefix with random host bits.
  task automatic random_item();
    int                pick;
    int                slot;
    logic [ADDR_W-1:0] pfx, nh, dst;
    logic [LEN_W-1:0]  len;
    logic [TTL_W-1:0]  ttl;
    pick = $urandom_range(99);
    pfx  = $urandom();
    nh   = $urandom();
    dst  = $urandom();
    ttl  = TTL_W'($urandom());
    len  = LEN_W'($urandom_range(63));
    if (added_cnt < TABLE_DEPTH && pick < 3) begin
      if (added_cnt == TABLE_DEPTH - 1) begin
        len = '0;
      end else if ($urandom_range(9) == 0) begin
        // same prefix and length again: the newer route must win
        slot = $urandom_range(added_cnt - 1);
        pfx  = known_pfx[slot];
        len  = LEN_W'(known_len[slot]);
      end else if ($urandom_range(9) < 8) begin
        len = LEN_W'($urandom_range(32, 1));
      end else begin
        len = LEN_W'($urandom_range(63, 33));
      end
      send_add(pfx, len, 1'($urandom_range(1)), nh, IFACE_W'($urandom_range(15)),
               dst, ttl);
    end else if (added_cnt == TABLE_DEPTH && pick < 10) begin
      send_add(pfx, len, 1'($urandom_range(1)), nh, IFACE_W'($urandom_range(15)),
               dst, ttl);
    end else begin
      if (added_cnt > 0 && $urandom_range(9) < 7) begin
        slot = $urandom_range(added_cnt - 1);
        dst  = known_pfx[slot] ^ ($urandom() >> known_len[slot]);
      end
      if ($urandom_range(4) == 0)
        ttl = TTL_W'($urandom_range(2));
      send(ACT_FWD, pack_item(pfx, len, 1'($urandom_range(1)), nh,
                              IFACE_W'($urandom_range(15)), dst, ttl));
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 16;
    recv_idle_pct = 58;

    // empty table: no route, also ahead of a dead TTL
    send_fwd(32'h0000_0000, 8'd0);
    send_fwd(32'hFFFF_FFFF, 8'd255);
    // build a small table, all-ones and all-zeros field values
    send_add(32'h0A00_0000, 6'd8, 1'b1, 32'hFFFF_FFFF, 4'd15, '0, '0);
    send_add(32'h0A01_0000, 6'd16, 1'b0, 32'h0000_0000, 4'd0, '0, '0);
    send_add(32'h0A01_0203, 6'd32, 1'b1, 32'h0000_0000, 4'd5, '0, '0);
    // length above 32 saturates to an exact match
    send_add(32'hC0A8_0000, 6'd63, 1'b0, 32'hDEAD_BEEF, 4'd9, '0, '0);
    // same /16 again: newer route shadows the older one
    send_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_00FE, 4'd3, '0, '0);
    send_add(32'h8000_0000, 6'd1, 1'b0, 32'h0000_0000, 4'd7, '0, '0);
    send_add(32'hFFFF_FFFE, 6'd31, 1'b1, 32'h1234_5678, 4'd10, '0, '0);
    // exact /32 beats the /16s and /8
    send_fwd(32'h0A01_0203, 8'd2);
    send_fwd(32'h0A01_0202, 8'd64);
    send_fwd(32'h0AC8_0001, 8'd255);
    // saturated /32, direct: hop is the destination
    send_fwd(32'hC0A8_0000, 8'd100);
    send_fwd(32'hC0A8_0001, 8'd100);
    // TTL of one and zero expire on a matching route
    send_fwd(32'hFFFF_FFFF, 8'd1);
    send_fwd(32'hFFFF_FFFE, 8'd0);
    send_fwd(32'h0100_0000, 8'd5);
    send_add(32'h7F00_0001, 6'd33, 1'b0, 32'h0000_0000, 4'd12, '0, '0);
    send_fwd(32'h7F00_0001, 8'd2);

    repeat (420) random_item();

    send_idle_pct = 58;
    recv_idle_pct = 16;
    repeat (400) random_item();

    // no idling; the receiver stall lands early in this phase
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    repeat (410) random_item();
    s_tvalid <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("ipv4_longest_prefix_router test passed");
    end else begin
      $display("ipv4_longest_prefix_router test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lpr_pkg.sv
rtl/lpr_ram.sv
rtl/lpr_match.sv
rtl/ipv4_longest_prefix_router.sv
dv/lpr_route_checker.sv
dv/testbench.sv
